FILE: design/swrl_pkg.sv
package swrl_pkg;

    localparam int TIME_W     = 40;
    localparam int WINDOW_W   = 32;
    localparam int LIMIT_W    = 5;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENHANCED_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENHANCED_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_PRESENT  = 3'd4;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET         = 32'd86400;
    localparam logic [LIMIT_W-1:0]  NORMAL_LIMIT_RESET   = 5'd3;
    localparam logic [LIMIT_W-1:0]  ENHANCED_LIMIT_RESET = 5'd3;
    localparam logic                ENHANCED_MODE_RESET  = 1'b0;
    localparam logic                STORE_PRESENT_RESET  = 1'b1;

    localparam logic ACTION_QUERY = 1'b0;
    localparam logic ACTION_ADD   = 1'b1;

endpackage

FILE: design/swrl_req_if.sv
interface swrl_req_if import swrl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [TIME_W-1:0] now_time;
    logic [TIME_W-1:0] log_stamp;

    modport source (
        output valid,
        output action,
        output now_time,
        output log_stamp,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  now_time,
        input  log_stamp,
        output ready
    );
endinterface

FILE: design/swrl_rsp_if.sv
interface swrl_rsp_if import swrl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               at_limit;
    logic               accepted;
    logic [COUNT_W-1:0] report_count;

    modport source (
        output valid,
        output at_limit,
        output accepted,
        output report_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  at_limit,
        input  accepted,
        input  report_count,
        output ready
    );
endinterface

FILE: design/swrl_ram.sv
module swrl_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/sliding_window_report_limiter_top.sv
// Channel | Direction | Payload                                   | Handshake
// req     | in        | action, now_time[39:0], log_stamp[39:0]   | valid/ready
// rsp     | out       | at_limit, accepted, report_count[4:0]     | valid/ready
// cfg     | in        | cfg_index[2:0], cfg_wdata[31:0]           | cfg_we, no wait
//
// An accepted item reads and checks the oldest log entry, popping it and going on while it
// has expired, with no check once the log is empty; req is ready only when back in idle.
// Each expiry is one read of the log RAM and one check.
// The result is registered; a held result stalls only the final decision step.
// Reset clears head, count, state, rsp valid and config; data regs and the log RAM are not.
module sliding_window_report_limiter_top import swrl_pkg::*; #(
    parameter int LOG_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    swrl_req_if.sink              req,
    swrl_rsp_if.source            rsp
);

    localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int PTR_W = $clog2(LOG_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FETCH  = 4'b0010,
        S_CHECK  = 4'b0100,
        S_DECIDE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [WINDOW_W-1:0] window_reg;
    logic [LIMIT_W-1:0]  normal_limit_reg;
    logic [LIMIT_W-1:0]  enhanced_limit_reg;
    logic                enhanced_mode_reg;
    logic                store_present_reg;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] count_reg, count_next;

    logic              action_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] stamp_reg;

    logic               rsp_valid_reg, rsp_valid_next;
    logic               at_limit_reg;
    logic               accepted_reg;
    logic [COUNT_W-1:0] rcount_reg;

    logic [TIME_W-1:0] ram_rdata;
    logic              ram_re;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [PTR_W:0]    tail_sum;
    logic [PTR_W:0]    tail_wrap;

    logic [TIME_W:0]    expiry_sum;
    logic               expire;
    logic [LIMIT_W-1:0] active_limit;
    logic               at_limit;
    logic               do_append;
    logic [PTR_W-1:0]   count_after;
    logic [31:0]        count_after_ext;
    logic               out_free;
    logic               req_fire;
    logic [IDX_W-1:0]   head_inc;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    assign expiry_sum = {1'b0, ram_rdata} + (TIME_W + 1)'(window_reg);
    assign expire     = expiry_sum < {1'b0, now_reg};
    assign head_inc   = (head_reg == IDX_W'(LOG_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign active_limit = (enhanced_mode_reg && store_present_reg) ?
                          enhanced_limit_reg : normal_limit_reg;
    assign at_limit     = 32'(count_reg) >= 32'(active_limit);
    assign do_append    = (action_reg == ACTION_ADD) && !at_limit && store_present_reg &&
                          (32'(count_reg) < 32'(LOG_DEPTH));
    assign count_after     = count_reg + PTR_W'(do_append);
    assign count_after_ext = 32'(count_after);

    assign tail_sum  = {1'b0, PTR_W'(head_reg)} + {1'b0, count_reg};
    assign tail_wrap = (tail_sum >= (PTR_W + 1)'(LOG_DEPTH)) ?
                       tail_sum - (PTR_W + 1)'(LOG_DEPTH) : tail_sum;
    assign ram_waddr = tail_wrap[IDX_W-1:0];

    assign ram_re = (state_reg == S_FETCH) && (count_reg != '0);
    assign ram_we = (state_reg == S_DECIDE) && out_free && do_append;

    swrl_ram #(
        .WIDTH (TIME_W),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (stamp_reg),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = (count_reg != '0) ? S_CHECK : S_DECIDE;
            end
            S_CHECK:
            begin
                if (expire)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    count_next     = count_after;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg         <= WINDOW_RESET;
            normal_limit_reg   <= NORMAL_LIMIT_RESET;
            enhanced_limit_reg <= ENHANCED_LIMIT_RESET;
            enhanced_mode_reg  <= ENHANCED_MODE_RESET;
            store_present_reg  <= STORE_PRESENT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_SECONDS: window_reg         <= cfg_wdata[WINDOW_W-1:0];
                CFG_NORMAL_LIMIT:   normal_limit_reg   <= cfg_wdata[LIMIT_W-1:0];
                CFG_ENHANCED_LIMIT: enhanced_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                CFG_ENHANCED_MODE:  enhanced_mode_reg  <= cfg_wdata[0];
                CFG_STORE_PRESENT:  store_present_reg  <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            action_reg <= req.action;
            now_reg    <= req.now_time;
            stamp_reg  <= req.log_stamp;
        end
        if ((state_reg == S_DECIDE) && out_free)
        begin
            at_limit_reg <= at_limit;
            accepted_reg <= do_append;
            rcount_reg   <= count_after_ext[COUNT_W-1:0];
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.at_limit     = at_limit_reg;
    assign rsp.accepted     = accepted_reg;
    assign rsp.report_count = rcount_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(LOG_DEPTH))
        else $error("log count exceeds the log depth");

    a_expire_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) && expire |=>
        (count_reg == $past(count_reg) - 1'b1) && (state_reg == S_FETCH))
        else $error("expired entry was not popped");

    a_accept_below: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.accepted |-> !rsp.at_limit)
        else $error("an add was stored at the limit");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=>
        (head_reg == $past(head_reg)) && (count_reg == $past(count_reg)))
        else $error("log pointers moved while idle");

endmodule
